FILE: sv/can_byte_role_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
`ifndef CAN_BYTE_ROLE_CLASSIFIER_DEFINES_SVH
`define CAN_BYTE_ROLE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define BRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/brc_pkg.sv
// Types and constants of the CAN byte role classifier.
`timescale 1ns / 1ps
package brc_pkg;

    localparam int LOG_W = 21;              // log2 result, Q5.16
    localparam logic [19:0] ENT_MAX = 20'd524288;
    localparam logic [19:0] ENT_STATE_LIMIT = 20'd163840;

    localparam logic [2:0] ROLE_CONSTANT = 3'd0;
    localparam logic [2:0] ROLE_CHECKSUM = 3'd1;
    localparam logic [2:0] ROLE_COUNTER  = 3'd2;
    localparam logic [2:0] ROLE_TOGGLE   = 3'd3;
    localparam logic [2:0] ROLE_STATE    = 3'd4;
    localparam logic [2:0] ROLE_VALUE    = 3'd5;

    typedef struct packed {
        logic [63:0] frame_bytes;
        logic [3:0]  frame_length;
        logic        final_frame;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  byte_position;
        logic [2:0]  byte_role;
        logic [7:0]  least_value;
        logic [7:0]  greatest_value;
        logic [8:0]  distinct_values;
        logic [19:0] entropy_q16;
        logic        last_position;
    } t_out_item;

    // per-frame update for one lane
    typedef struct packed {
        logic       en;
        logic       first;
        logic [7:0] value;
        logic       xor_zero;   // xor of all active bytes is zero
    } t_upd_cmd;

    // batch control to all lanes
    typedef struct packed {
        logic        start;
        logic        clear;
        logic        multi;     // batch length >= 2
        logic [15:0] min_frames;
    } t_run_cmd;

    typedef struct packed {
        logic [2:0]  role;
        logic [7:0]  least;
        logic [7:0]  greatest;
        logic [8:0]  distinct;
        logic [19:0] entropy;
    } t_lane_res;

endpackage

FILE: sv/brc_ram.sv
// Generic single-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module brc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/brc_log.sv
// Iterative log2 in Q5.16: normalize, then one squaring per fraction bit.
`timescale 1ns / 1ps
module brc_log #(
    parameter int COUNT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [COUNT_BITS-1:0]      i_x,
    output logic                       o_done,
    output logic [brc_pkg::LOG_W-1:0]  o_log
);

    logic        r_busy, n_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [4:0]  r_k;
    logic [30:0] r_m;
    logic [15:0] r_frac;

    logic [4:0]  k;
    logic [62:0] wide;
    logic [30:0] m_norm;
    logic [61:0] sq;
    logic [31:0] t;

    always_comb begin
        k = 5'd0;
        for (int i = 0; i < COUNT_BITS; i++) begin
            if (i_x[i]) begin
                k = 5'(i);
            end
        end
        wide = 63'(i_x);
        if (k <= 5'd30) begin
            m_norm = 31'(wide << (5'd30 - k));
        end else begin
            m_norm = 31'(wide >> (k - 5'd30));
        end
    end

    assign sq = 62'(r_m) * 62'(r_m);
    assign t  = sq[61:30];
    assign n_busy = i_start ? 1'b1 : (r_busy && r_cnt != 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && r_cnt == 4'd0 && !i_start;
        end
        if (i_start) begin
            r_k    <= k;
            r_m    <= m_norm;
            r_frac <= 16'd0;
            r_cnt  <= 4'd15;
        end else if (r_busy) begin
            if (t[31]) begin
                r_m           <= t[31:1];
                r_frac[r_cnt] <= 1'b1;
            end else begin
                r_m <= t[30:0];
            end
            r_cnt <= r_cnt - 4'd1;
        end
    end

    assign o_done = r_done;
    assign o_log  = {r_k, r_frac};

endmodule

FILE: sv/brc_lane.sv
// One byte-position lane: histogram, statistics, entropy and role.
`timescale 1ns / 1ps
module brc_lane #(
    parameter int COUNT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  brc_pkg::t_upd_cmd      i_upd,
    input  brc_pkg::t_run_cmd      i_run,
    input  logic [COUNT_BITS-1:0]  i_frames,
    output logic                   o_busy,
    output logic                   o_done,
    output brc_pkg::t_lane_res     o_res
);

    localparam int QW = brc_pkg::LOG_W;
    localparam int SW = COUNT_BITS + QW;

    localparam logic [3:0] L_CLR  = 4'd0;
    localparam logic [3:0] L_IDLE = 4'd1;
    localparam logic [3:0] L_NLOG = 4'd2;
    localparam logic [3:0] L_BRD  = 4'd3;
    localparam logic [3:0] L_BCHK = 4'd4;
    localparam logic [3:0] L_BLOG = 4'd5;
    localparam logic [3:0] L_BACC = 4'd6;
    localparam logic [3:0] L_DSET = 4'd7;
    localparam logic [3:0] L_DIV  = 4'd8;
    localparam logic [3:0] L_ROLE = 4'd9;
    localparam logic [3:0] L_DONE = 4'd10;

    logic [3:0]            r_state;
    logic [7:0]            r_bin;
    logic                  r_pend, r_pfirst, r_pxz;
    logic [7:0]            r_pval, r_prev;
    logic [7:0]            r_least, r_greatest;
    logic [COUNT_BITS-1:0] r_step, r_xor, r_c, r_rem;
    logic [8:0]            r_dist;
    logic [SW-1:0]         r_top, r_s, r_prod;
    logic [QW-1:0]         r_dlo, r_q;
    logic [4:0]            r_cnt;
    brc_pkg::t_lane_res    r_res;

    logic                  wr_en;
    logic [7:0]            wr_addr, rd_addr;
    logic [COUNT_BITS-1:0] wr_data, rd_data;
    logic                  log_start, log_done;
    logic [COUNT_BITS-1:0] log_x;
    logic [QW-1:0]         log_val;
    logic [SW-1:0]         diff;
    logic [COUNT_BITS:0]   rem2;
    logic                  ge;
    logic [19:0]           ent;
    logic [COUNT_BITS+6:0] xor_lhs, xor_rhs, step_lhs, step_rhs;
    logic [2:0]            role;

    brc_ram #(.WIDTH(COUNT_BITS), .DEPTH(256)) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    brc_log #(.COUNT_BITS(COUNT_BITS)) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_log   (log_val)
    );

    always_comb begin
        rd_addr = (r_state == L_IDLE) ? i_upd.value : r_bin;
        wr_en   = 1'b0;
        wr_addr = r_bin;
        wr_data = '0;
        if (r_state == L_CLR || r_state == L_BRD) begin
            wr_en = 1'b1;
        end else if (r_state == L_IDLE && r_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_pval;
            wr_data = rd_data + COUNT_BITS'(1);
        end
    end

    assign log_start = (r_state == L_IDLE && i_run.start)
                    || (r_state == L_BCHK && rd_data != '0);
    assign log_x     = (r_state == L_IDLE) ? i_frames : rd_data;

    assign diff = (r_top > r_s) ? (r_top - r_s) : '0;
    assign rem2 = {r_rem, r_dlo[QW-1]};
    assign ge   = rem2 >= {1'b0, i_frames};

    always_comb begin
        if (i_frames == '0) begin
            ent = 20'd0;
        end else if (r_q > QW'(brc_pkg::ENT_MAX)) begin
            ent = brc_pkg::ENT_MAX;
        end else begin
            ent = r_q[19:0];
        end
        xor_lhs  = (COUNT_BITS+7)'(r_xor) * (COUNT_BITS+7)'(100);
        xor_rhs  = (COUNT_BITS+7)'(i_frames) * (COUNT_BITS+7)'(85);
        step_lhs = (COUNT_BITS+7)'(r_step) * (COUNT_BITS+7)'(100);
        step_rhs = (COUNT_BITS+7)'(i_frames - COUNT_BITS'(1)) * (COUNT_BITS+7)'(70);
        if (r_dist <= 9'd1) begin
            role = brc_pkg::ROLE_CONSTANT;
        end else if (32'(i_frames) >= 32'(i_run.min_frames) && i_run.multi
                     && xor_lhs >= xor_rhs) begin
            role = brc_pkg::ROLE_CHECKSUM;
        end else if (i_frames >= COUNT_BITS'(2) && step_lhs >= step_rhs) begin
            role = brc_pkg::ROLE_COUNTER;
        end else if (r_dist == 9'd2) begin
            role = brc_pkg::ROLE_TOGGLE;
        end else if (r_dist <= 9'd8 && ent < brc_pkg::ENT_STATE_LIMIT) begin
            role = brc_pkg::ROLE_STATE;
        end else begin
            role = brc_pkg::ROLE_VALUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= L_CLR;
            r_bin      <= 8'd0;
            r_pend     <= 1'b0;
            r_least    <= 8'hFF;
            r_greatest <= 8'h00;
            r_step     <= '0;
            r_xor      <= '0;
        end else begin
            unique case (r_state)
                L_CLR: begin
                    r_bin <= r_bin + 8'd1;
                    if (r_bin == 8'hFF) begin
                        r_state <= L_IDLE;
                    end
                end
                L_IDLE: begin
                    r_pend   <= i_upd.en;
                    r_pval   <= i_upd.value;
                    r_pfirst <= i_upd.first;
                    r_pxz    <= i_upd.xor_zero;
                    if (r_pend) begin
                        if (r_pval < r_least) r_least <= r_pval;
                        if (r_pval > r_greatest) r_greatest <= r_pval;
                        if (!r_pfirst && r_pval == r_prev + 8'd1) begin
                            r_step <= r_step + COUNT_BITS'(1);
                        end
                        if (r_pxz) begin
                            r_xor <= r_xor + COUNT_BITS'(1);
                        end
                        r_prev <= r_pval;
                    end
                    if (i_run.start) begin
                        r_bin   <= 8'd0;
                        r_s     <= '0;
                        r_dist  <= 9'd0;
                        r_state <= L_NLOG;
                    end
                end
                L_NLOG: begin
                    if (log_done) begin
                        r_top   <= SW'(i_frames) * SW'(log_val);
                        r_state <= L_BRD;
                    end
                end
                L_BRD: begin
                    r_state <= L_BCHK;
                end
                L_BCHK: begin
                    if (rd_data != '0) begin
                        r_dist  <= r_dist + 9'd1;
                        r_c     <= rd_data;
                        r_state <= L_BLOG;
                    end else begin
                        r_bin   <= r_bin + 8'd1;
                        r_state <= (r_bin == 8'hFF) ? L_DSET : L_BRD;
                    end
                end
                L_BLOG: begin
                    if (log_done) begin
                        r_prod  <= SW'(r_c) * SW'(log_val);
                        r_state <= L_BACC;
                    end
                end
                L_BACC: begin
                    r_s     <= r_s + r_prod;
                    r_bin   <= r_bin + 8'd1;
                    r_state <= (r_bin == 8'hFF) ? L_DSET : L_BRD;
                end
                L_DSET: begin
                    r_rem   <= diff[SW-1:QW];
                    r_dlo   <= diff[QW-1:0];
                    r_q     <= '0;
                    r_cnt   <= 5'(QW - 1);
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    r_rem   <= ge ? COUNT_BITS'(rem2 - {1'b0, i_frames})
                                  : COUNT_BITS'(rem2);
                    r_q     <= {r_q[QW-2:0], ge};
                    r_dlo   <= {r_dlo[QW-2:0], 1'b0};
                    r_cnt   <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= L_ROLE;
                    end
                end
                L_ROLE: begin
                    r_res.role     <= role;
                    r_res.least    <= r_least;
                    r_res.greatest <= r_greatest;
                    r_res.distinct <= r_dist;
                    r_res.entropy  <= ent;
                    r_state        <= L_DONE;
                end
                L_DONE: begin
                    if (i_run.clear) begin
                        r_least    <= 8'hFF;
                        r_greatest <= 8'h00;
                        r_step     <= '0;
                        r_xor      <= '0;
                        r_state    <= L_IDLE;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_busy = r_state != L_IDLE;
    assign o_done = r_state == L_DONE;
    assign o_res  = r_res;

endmodule

FILE: sv/can_byte_role_classifier.sv
// Top level of the CAN byte role classifier: frame intake, lanes, result merge.
`timescale 1ns / 1ps
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_data): one CAN frame per
//   transaction. The first frame of a batch fixes its byte count; the frame
//   with final_frame set closes the batch.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one transaction
//   per byte position 0..len-1, last_position set on the final one.
//   Config: i_cfg_wr_en/i_cfg_wr_data write min_frames only while idle; user rule, unchecked.
// Timing
//   A frame reads its histogram bin at acceptance and writes the increment in
//   the next cycle (one RAM port pair per lane).
//   A final frame then runs the classification: every lane takes the log of the
//   frame count, walks its 256 bins, takes each nonzero bin through the squaring
//   log unit, then runs the divide. The results follow, one result per cycle
//   while not stalled.
// Reset
//   After reset each lane clears all 256 bins of its histogram, with o_in_stall
//   high. A stalled result holds; the block stays in its output phase until
//   all results are taken, then clears the batch state and takes frames again.
`include "can_byte_role_classifier_defines.svh"
module can_byte_role_classifier #(
    parameter int BYTE_POSITIONS = 8,
    parameter int COUNT_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  brc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output brc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data
);

    localparam int LW = $clog2(BYTE_POSITIONS + 1);
    localparam int IW = $clog2(BYTE_POSITIONS);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_WR   = 3'd1;
    localparam logic [2:0] T_RUN  = 3'd2;
    localparam logic [2:0] T_WAIT = 3'd3;
    localparam logic [2:0] T_EMIT = 3'd4;
    localparam logic [2:0] T_CLR  = 3'd5;

    logic [2:0]            r_state;
    logic [COUNT_BITS-1:0] r_frames;
    logic [LW-1:0]         r_len, r_pos;
    logic                  r_fin;
    logic [15:0]           r_min_frames;
    logic                  r_out_valid;
    brc_pkg::t_out_item    r_out;

    logic                  accept, upd_ok;
    logic [LW-1:0]         eff_len, len_now;
    logic [7:0]            xall;
    brc_pkg::t_upd_cmd     upd [BYTE_POSITIONS];
    brc_pkg::t_run_cmd     run;
    brc_pkg::t_lane_res    lane_res [BYTE_POSITIONS];
    brc_pkg::t_lane_res    sel;
    logic [BYTE_POSITIONS-1:0] lane_busy, lane_done;

    assign o_in_stall = (r_state != T_IDLE) || (|lane_busy);
    assign accept     = i_in_valid && !o_in_stall;
    // frames past the count limit change no statistics; their final flag still closes the batch
    assign upd_ok     = r_frames != '1;

    // length code clamps to the lane count
    assign eff_len = (i_in_data.frame_length > 4'(BYTE_POSITIONS))
                   ? LW'(BYTE_POSITIONS) : LW'(i_in_data.frame_length);
    assign len_now = (r_frames == '0) ? eff_len : r_len;

    // a byte equals the xor of the others iff the xor of all active bytes is 0
    always_comb begin
        xall = 8'd0;
        for (int b = 0; b < BYTE_POSITIONS; b++) begin
            if (32'(b) < 32'(len_now)) begin
                xall = xall ^ i_in_data.frame_bytes[63-8*b -: 8];
            end
        end
    end

    assign run.start      = r_state == T_RUN;
    assign run.clear      = r_state == T_CLR;
    assign run.multi      = 32'(r_len) >= 32'd2;
    assign run.min_frames = r_min_frames;

    for (genvar g = 0; g < BYTE_POSITIONS; g++) begin : g_lane
        assign upd[g].en       = accept && upd_ok && (32'(g) < 32'(len_now));
        assign upd[g].first    = r_frames == '0;
        assign upd[g].value    = i_in_data.frame_bytes[63-8*g -: 8];
        assign upd[g].xor_zero = xall == 8'd0;

        brc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_upd    (upd[g]),
            .i_run    (run),
            .i_frames (r_frames),
            .o_busy   (lane_busy[g]),
            .o_done   (lane_done[g]),
            .o_res    (lane_res[g])
        );
    end

    // merge: lanes are read out in position order
    assign sel = lane_res[r_pos[IW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_frames     <= '0;
            r_len        <= '0;
            r_pos        <= '0;
            r_fin        <= 1'b0;
            r_min_frames <= 16'd10;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_min_frames <= i_cfg_wr_data;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        if (upd_ok) begin
                            r_frames <= r_frames + COUNT_BITS'(1);
                            if (r_frames == '0) begin
                                r_len <= eff_len;
                            end
                        end
                        r_fin   <= i_in_data.final_frame;
                        r_state <= T_WR;
                    end
                end
                T_WR: begin
                    r_state <= r_fin ? T_RUN : T_IDLE;
                end
                T_RUN: begin
                    r_state <= T_WAIT;
                end
                T_WAIT: begin
                    if (&lane_done) begin
                        r_pos   <= '0;
                        r_state <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        if (r_pos < r_len) begin
                            r_out.byte_position   <= 3'(r_pos);
                            r_out.byte_role       <= sel.role;
                            r_out.least_value     <= sel.least;
                            r_out.greatest_value  <= sel.greatest;
                            r_out.distinct_values <= sel.distinct;
                            r_out.entropy_q16     <= sel.entropy;
                            r_out.last_position   <= (r_pos + LW'(1)) == r_len;
                            r_out_valid           <= 1'b1;
                            r_pos                 <= r_pos + LW'(1);
                        end else begin
                            r_out_valid <= 1'b0;
                            r_state     <= T_CLR;
                        end
                    end
                end
                T_CLR: begin
                    r_frames <= '0;
                    r_len    <= '0;
                    r_fin    <= 1'b0;
                    r_state  <= T_IDLE;
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BRC_ASSERT_NOW(a_no_accept_in_output, i_clk, i_rst_n, accept, !r_out_valid, "frame taken while results pending")
    `BRC_ASSERT_NOW(a_last_matches_len, i_clk, i_rst_n, r_out_valid && r_out.last_position, r_pos == r_len, "last flag off the batch length")
    `BRC_ASSERT_NOW(a_emit_lanes_done, i_clk, i_rst_n, r_state == T_EMIT, &lane_done, "output phase before all lanes finished")
    `BRC_ASSERT_NEXT(a_clear_resets_count, i_clk, i_rst_n, r_state == T_CLR, r_frames == '0 && r_state == T_IDLE, "batch not cleared")

endmodule

FILE: test/tb.sv
// Testbench for can_byte_role_classifier: batch stimulus, scoreboard, checks.
`timescale 1ns / 1ps
module tb;

    localparam int NPOS        = 8;
    localparam int COUNT_LIMIT = 65535;     // frame count saturation point
    localparam int WATCHDOG    = 40000;     // quiet cycles before giving up
    localparam int SETTLE      = 6000;      // covers the worst-case classification time

    // byte content generators per position
    localparam int GEN_CONST   = 0;
    localparam int GEN_COUNTER = 1;
    localparam int GEN_TOGGLE  = 2;
    localparam int GEN_STATE   = 3;
    localparam int GEN_RANDOM  = 4;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_stall;
    brc_pkg::t_in_item    in_data;
    logic                 out_valid;
    logic                 out_stall;
    brc_pkg::t_out_item   out_data;
    logic                 cfg_wr_en;
    logic [15:0]          cfg_wr_data;

    int  errors;
    int  results_seen;
    int  frames_sent;
    int  batches_sent;
    bit  idling_on;
    int  quiet_cycles;

    can_byte_role_classifier dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_data    (in_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_data   (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // log2 in Q.16 by repeated squaring of a Q1.30 mantissa
    function automatic logic [63:0] log2_q16(input logic [63:0] x);
        int          k;
        logic [63:0] m;
        logic [63:0] frac;
        if (x == 0) return 0;
        k = 0;
        while (k < 63 && (x >> (k + 1)) != 0) k++;
        m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
        frac = 0;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(k) << 16) | frac;
    endfunction

    // Shadow of the batch statistics; predicts the per-position summaries.
    class role_scoreboard;
        int unsigned        hist[NPOS][256];
        logic [7:0]         least[NPOS];
        logic [7:0]         greatest[NPOS];
        logic [63:0]        prev_bytes;
        int unsigned        steps[NPOS];
        int unsigned        xor_hits[NPOS];
        int unsigned        frames;
        int unsigned        batch_len;
        int unsigned        min_frames;
        brc_pkg::t_out_item expected_summaries[$];

        function void clear();
            foreach (hist[b, v]) hist[b][v] = 0;
            for (int b = 0; b < NPOS; b++) begin
                least[b] = 8'hFF;
                greatest[b] = 8'h00;
                steps[b] = 0;
                xor_hits[b] = 0;
            end
            prev_bytes = 0;
            frames = 0;
            batch_len = 0;
        endfunction

        function void set_min_frames(input logic [15:0] v);
            min_frames = v;
        endfunction

        function int unsigned active_len();
            return (batch_len > NPOS) ? NPOS : batch_len;
        endfunction

        function void note_frame(input brc_pkg::t_in_item it);
            int unsigned len;
            logic [7:0]  v;
            logic [7:0]  x;
            if (frames < COUNT_LIMIT) begin
                if (frames == 0) batch_len = it.frame_length;
                len = active_len();
                for (int b = 0; b < len; b++) begin
                    v = it.frame_bytes[63 - 8*b -: 8];
                    hist[b][v]++;
                    if (v < least[b]) least[b] = v;
                    if (v > greatest[b]) greatest[b] = v;
                    if (frames > 0 && v == 8'(prev_bytes[63 - 8*b -: 8] + 8'd1)) steps[b]++;
                    x = 0;
                    for (int o = 0; o < len; o++)
                        if (o != b) x ^= it.frame_bytes[63 - 8*o -: 8];
                    if (x == v) xor_hits[b]++;
                end
                prev_bytes = it.frame_bytes;
                frames++;
            end
            if (it.final_frame) begin
                summarize();
                clear();
            end
        endfunction

        function void summarize();
            int unsigned        len;
            logic [63:0]        n, s, top, ent;
            int unsigned        distinct;
            brc_pkg::t_out_item r;
            len = active_len();
            n = frames;
            for (int b = 0; b < len; b++) begin
                s = 0;
                distinct = 0;
                for (int v = 0; v < 256; v++)
                    if (hist[b][v] != 0) begin
                        distinct++;
                        s += 64'(hist[b][v]) * log2_q16(hist[b][v]);
                    end
                ent = 0;
                if (n != 0) begin
                    top = n * log2_q16(n);
                    ent = (top > s) ? (top - s) / n : 0;
                    if (ent > 64'(brc_pkg::ENT_MAX)) ent = 64'(brc_pkg::ENT_MAX);
                end
                if (distinct <= 1)
                    r.byte_role = brc_pkg::ROLE_CONSTANT;
                else if (n >= min_frames && len >= 2 && 64'(xor_hits[b]) * 100 >= 85 * n)
                    r.byte_role = brc_pkg::ROLE_CHECKSUM;
                else if (n >= 2 && 64'(steps[b]) * 100 >= 70 * (n - 1))
                    r.byte_role = brc_pkg::ROLE_COUNTER;
                else if (distinct == 2)
                    r.byte_role = brc_pkg::ROLE_TOGGLE;
                else if (distinct <= 8 && ent < 64'(brc_pkg::ENT_STATE_LIMIT))
                    r.byte_role = brc_pkg::ROLE_STATE;
                else
                    r.byte_role = brc_pkg::ROLE_VALUE;
                r.byte_position   = 3'(b);
                r.least_value     = least[b];
                r.greatest_value  = greatest[b];
                r.distinct_values = 9'(distinct);
                r.entropy_q16     = 20'(ent);
                r.last_position   = (b + 1 == len);
                expected_summaries = {expected_summaries, r};
            end
        endfunction

        task check_summary(input brc_pkg::t_out_item got);
            brc_pkg::t_out_item want;
            if (expected_summaries.size() == 0) begin
                report_mismatch("unexpected result, position", got.byte_position, -1);
                return;
            end
            want = expected_summaries.pop_front();
            if (got.byte_position != want.byte_position)
                report_mismatch("byte_position", got.byte_position, want.byte_position);
            if (got.byte_role != want.byte_role)
                report_mismatch("byte_role", got.byte_role, want.byte_role);
            if (got.least_value != want.least_value)
                report_mismatch("least_value", got.least_value, want.least_value);
            if (got.greatest_value != want.greatest_value)
                report_mismatch("greatest_value", got.greatest_value, want.greatest_value);
            if (got.distinct_values != want.distinct_values)
                report_mismatch("distinct_values", got.distinct_values, want.distinct_values);
            if (got.entropy_q16 != want.entropy_q16)
                report_mismatch("entropy_q16", got.entropy_q16, want.entropy_q16);
            if (got.last_position != want.last_position)
                report_mismatch("last_position", got.last_position, want.last_position);
        endtask
    endclass

    role_scoreboard sb;

    // per-position generator state used when building a batch
    int         gen_kind[NPOS];
    logic [7:0] gen_base[NPOS];
    logic [7:0] gen_alt[NPOS];
    bit         gen_checksum;     // force whole-frame xor to zero
    int         gen_sum_pos;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // random idle burst length, 0 when no idling
    function automatic int idle_burst(input int one_in);
        if (!idling_on) return 0;
        if ($urandom_range(one_in - 1) != 0) return 0;
        return $urandom_range(17, 1);
    endfunction

    // result side: check each accepted transaction, stall in random bursts
    int out_burst;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                sb.check_summary(out_data);
                results_seen++;
            end
            if (out_burst > 0) begin
                out_burst--;
                out_stall <= 1'b1;
            end else begin
                out_burst = idle_burst(6);
                out_stall <= (out_burst > 0);
                if (out_burst > 0) out_burst--;
            end
        end
    end

    // watchdog: quiet cycles on both channels
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d results pending",
                     sb.expected_summaries.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one frame transaction; the scoreboard sees it once it is accepted
    task automatic send_frame(input logic [63:0] data, input logic [3:0] len, input bit fin);
        brc_pkg::t_in_item it;
        int                gap;
        it.frame_bytes  = data;
        it.frame_length = len;
        it.final_frame  = fin;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        sb.note_frame(it);
        frames_sent++;
        if (fin) batches_sent++;
        gap = idle_burst(5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_summaries.size() != 0) @(posedge i_clk);
    endtask

    // min_frames may only change while the block is idle
    task automatic write_min_frames(input logic [15:0] v);
        in_valid <= 1'b0;
        drain();
        repeat (SETTLE) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        sb.set_min_frames(v);
    endtask

    function automatic logic [63:0] make_frame(input int idx);
        logic [63:0] d;
        logic [7:0]  v;
        logic [7:0]  x;
        for (int b = 0; b < NPOS; b++) begin
            case (gen_kind[b])
                GEN_CONST:   v = gen_base[b];
                GEN_COUNTER: v = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(gen_base[b] + idx);
                GEN_TOGGLE:  v = $urandom_range(1) ? gen_base[b] : gen_alt[b];
                GEN_STATE:   v = gen_base[b] + 8'($urandom_range(4));
                default:     v = 8'($urandom);
            endcase
            d[63 - 8*b -: 8] = v;
        end
        if (gen_checksum) begin
            x = 0;
            for (int o = 0; o < NPOS; o++)
                if (o != gen_sum_pos) x ^= d[63 - 8*o -: 8];
            d[63 - 8*gen_sum_pos -: 8] = x;
        end
        return d;
    endfunction

    function automatic void pick_generators();
        for (int b = 0; b < NPOS; b++) begin
            gen_kind[b] = $urandom_range(GEN_RANDOM);
            gen_base[b] = 8'($urandom);
            gen_alt[b]  = 8'($urandom);
        end
        gen_checksum = ($urandom_range(2) == 0);
        gen_sum_pos  = $urandom_range(NPOS - 1);
    endfunction

    // frames of one batch; len applies to the first, final set on the last
    task automatic send_batch(input int nframes, input logic [3:0] len);
        for (int i = 0; i < nframes; i++)
            send_frame(make_frame(i), (i == 0) ? len : 4'($urandom), i == nframes - 1);
    endtask

    int random_items;

    initial begin
        sb = new();
        sb.clear();
        sb.set_min_frames(16'd10);
        errors = 0;
        results_seen = 0;
        frames_sent = 0;
        batches_sent = 0;
        quiet_cycles = 0;
        out_burst = 0;
        idling_on = 1'b1;
        in_valid    <= 1'b0;
        in_data     <= '0;
        out_stall   <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, each role, the special cases.
        send_frame(64'h0, 4'd8, 1'b1);                         // single frame, all zero
        send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0);      // length above positions
        send_frame(64'h0, 4'd0, 1'b1);
        send_frame(64'h1234_5678_9ABC_DEF0, 4'd0, 1'b1);       // zero length: no results
        send_frame(64'hA5A5_A5A5_A5A5_A5A5, 4'd1, 1'b0);       // one byte, no checksum
        send_frame(64'h5A00_0000_0000_0000, 4'd1, 1'b1);
        for (int b = 0; b < NPOS; b++) begin
            gen_kind[b] = b % 5;
            gen_base[b] = 8'(b * 37);
            gen_alt[b]  = 8'(b * 91 + 1);
        end
        gen_checksum = 1'b1;
        gen_sum_pos = 7;
        send_batch(12, 4'd8);                                  // counter/toggle/state/checksum
        write_min_frames(16'd1);
        send_frame(64'h0102_0300_0000_0000, 4'd3, 1'b1);       // zero-xor single frame: constant wins over checksum

        // Sender holds off until every summary is back, then a fresh batch.
        drain();
        write_min_frames(16'd65535);
        pick_generators();
        send_batch(20, 4'd8);
        write_min_frames(16'd10);

        // Random batches with random generators; a few broken or noisy ones.
        random_items = 0;
        while (random_items < 365) begin
            if (random_items > 150 && random_items < 170)
                write_min_frames(16'($urandom_range(40, 2)));
            if (random_items > 300) idling_on = 1'b0;
            pick_generators();
            case ($urandom_range(9))
                0: begin
                    for (int b = 0; b < NPOS; b++) gen_kind[b] = GEN_RANDOM;
                    send_batch(1, 4'($urandom));               // final on first frame
                    random_items += 1;
                end
                1: begin
                    for (int b = 0; b < NPOS; b++) gen_kind[b] = GEN_RANDOM;
                    send_batch(40, 4'($urandom_range(15, 2))); // wide histograms
                    random_items += 40;
                end
                default: begin
                    int nf;
                    nf = $urandom_range(30, 2);
                    send_batch(nf, ($urandom_range(3) == 0) ? 4'($urandom)
                                                            : 4'($urandom_range(8, 2)));
                    random_items += nf;
                end
            endcase
        end
        in_valid <= 1'b0;

        drain();
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d frames in %0d batches, %0d byte summaries checked",
                 frames_sent, batches_sent, results_seen);
        $display("including zero and clamped lengths and min_frames at 1, 10, 65535 and random");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
